FILE: design/rdwr_pkg.sv
// Shared types, constants and controller/datapath interface structs of the draw pool.
`default_nettype none
package rdwr_pkg;

	// Pool geometry.
	localparam int POOL_DEPTH = 64;
	localparam int ADDR_W     = $clog2(POOL_DEPTH);
	localparam int COUNT_W    = $clog2(POOL_DEPTH + 1);

	// Fixed field widths.
	localparam int ENTRY_W  = 8;
	localparam int RND_W    = 16;
	localparam int REMAIN_W = 7;
	localparam int STATUS_W = 2;
	localparam int STEP_W   = $clog2(RND_W);

	// Request commands.
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_DRAW = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic               cmd;
		logic [ENTRY_W-1:0] entry_value;
		logic [RND_W-1:0]   random_word;
	} in_req_t;

	typedef struct packed {
		logic [ENTRY_W-1:0]  drawn_value;
		logic [REMAIN_W-1:0] remaining_count;
		logic [STATUS_W-1:0] status;
	} out_req_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic load_wr;
		logic set_full;
		logic set_empty;
		logic div_step;
		logic rd_pos;
		logic cap_drawn;
		logic sh_rd;
		logic sh_wr;
		logic commit_draw;
		logic out_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic               is_draw;
		logic               full;
		logic               empty;
		logic               div_last;
		logic               shift_more;
		logic [COUNT_W-1:0] count;
	} dp_sts_t;

endpackage
`default_nettype wire

FILE: design/random_draw_without_replacement_unit.sv
// Top level of the draw pool: controller and datapath joined by command and status structs.
// A load or an error request goes from capture through the execute state to the result; a draw
// also runs the bit-serial modulo unit, reads the entry at the drawn position and closes the
// gap by moving each entry above it down one place, with a read and then a write of the pool
// memory per entry. One request is in work at a time; the next is accepted the cycle after
// the result is registered. Reset clears the count and handshake.
`default_nettype none
module random_draw_without_replacement_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire rdwr_pkg::in_req_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output rdwr_pkg::out_req_t      out_data
);

	// Commands flow from the controller into the datapath, status flows back.
	rdwr_pkg::dp_cmd_t dp_cmd;
	rdwr_pkg::dp_sts_t dp_sts;

	// The controller walks each request through its steps: capture, load or modulo,
	// reading the chosen entry, then closing the gap one entry at a time.
	rdwr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (dp_sts),
		.cmd       (dp_cmd)
	);

	// The datapath holds the pool memory, the entry count, the serial modulo unit
	// and the output register that lets a finished result wait for the consumer.
	rdwr_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (dp_cmd),
		.sts      (dp_sts),
		.out_data (out_data)
	);

	// The pool count can never pass the pool depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dp_sts.count <= rdwr_pkg::COUNT_W'(rdwr_pkg::POOL_DEPTH))
		else $error("pool count exceeds depth");

	// An accepted request keeps the block busy on the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("block ready right after accepting a request");

	// Loads and errors report a zero drawn value.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status != rdwr_pkg::STATUS_OK) |-> out_data.drawn_value == '0)
		else $error("error result carries a drawn value");

	// A full-pool error reports the pool as full.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == rdwr_pkg::STATUS_FULL)
		|-> out_data.remaining_count == rdwr_pkg::REMAIN_W'(rdwr_pkg::POOL_DEPTH))
		else $error("full status with wrong remaining count");

endmodule
`default_nettype wire

FILE: design/rdwr_datapath.sv
// Datapath of the draw pool: pool memory, count, serial modulo unit and result register.
`default_nettype none
module rdwr_datapath (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire rdwr_pkg::in_req_t          in_data,
	input  wire rdwr_pkg::dp_cmd_t          cmd,
	output rdwr_pkg::dp_sts_t               sts,
	output rdwr_pkg::out_req_t              out_data
);

	logic [rdwr_pkg::ENTRY_W-1:0] mem [rdwr_pkg::POOL_DEPTH];

	rdwr_pkg::in_req_t                item_q;
	logic [rdwr_pkg::COUNT_W-1:0]     count_q;
	logic [rdwr_pkg::COUNT_W-1:0]     rem_q;
	logic [rdwr_pkg::RND_W-1:0]       rnd_q;
	logic [rdwr_pkg::STEP_W-1:0]      step_q;
	logic [rdwr_pkg::ADDR_W-1:0]      k_q;
	logic [rdwr_pkg::ENTRY_W-1:0]     drawn_q;
	logic [rdwr_pkg::STATUS_W-1:0]    status_q;
	logic [rdwr_pkg::ENTRY_W-1:0]     rd_data_q;
	rdwr_pkg::out_req_t               out_q;

	logic [rdwr_pkg::COUNT_W:0]       part;
	logic [rdwr_pkg::COUNT_W-1:0]     rem_next;
	logic [rdwr_pkg::COUNT_W-1:0]     k_plus1;
	logic                             mem_we;
	logic [rdwr_pkg::ADDR_W-1:0]      waddr;
	logic [rdwr_pkg::ENTRY_W-1:0]     wdata;
	logic                             mem_re;
	logic [rdwr_pkg::ADDR_W-1:0]      raddr;

	// One restoring division step: bring in the next dividend bit, subtract if it fits.
	always_comb begin
		part = {rem_q, rnd_q[rdwr_pkg::RND_W-1]};
		if (part >= {1'b0, count_q}) begin
			rem_next = rdwr_pkg::COUNT_W'(part - {1'b0, count_q});
		end else begin
			rem_next = rdwr_pkg::COUNT_W'(part);
		end
	end

	assign k_plus1 = rdwr_pkg::COUNT_W'(k_q) + rdwr_pkg::COUNT_W'(1);

	assign mem_we = cmd.load_wr | cmd.sh_wr;
	assign waddr  = cmd.load_wr ? rdwr_pkg::ADDR_W'(count_q) : k_q;
	assign wdata  = cmd.load_wr ? item_q.entry_value : rd_data_q;
	assign mem_re = cmd.rd_pos | cmd.sh_rd;
	assign raddr  = cmd.rd_pos ? rdwr_pkg::ADDR_W'(rem_q) : rdwr_pkg::ADDR_W'(k_plus1);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.load_wr) begin
			count_q <= count_q + rdwr_pkg::COUNT_W'(1);
		end else if (cmd.commit_draw) begin
			count_q <= count_q - rdwr_pkg::COUNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q   <= in_data;
			rnd_q    <= in_data.random_word;
			rem_q    <= '0;
			step_q   <= '0;
			drawn_q  <= '0;
			status_q <= rdwr_pkg::STATUS_OK;
		end
		if (cmd.set_full) begin
			status_q <= rdwr_pkg::STATUS_FULL;
		end
		if (cmd.set_empty) begin
			status_q <= rdwr_pkg::STATUS_EMPTY;
		end
		if (cmd.div_step) begin
			rem_q  <= rem_next;
			rnd_q  <= {rnd_q[rdwr_pkg::RND_W-2:0], 1'b0};
			step_q <= step_q + rdwr_pkg::STEP_W'(1);
		end
		if (cmd.rd_pos) begin
			k_q <= rdwr_pkg::ADDR_W'(rem_q);
		end
		if (cmd.cap_drawn) begin
			drawn_q <= rd_data_q;
		end
		if (cmd.sh_wr) begin
			k_q <= rdwr_pkg::ADDR_W'(k_plus1);
		end
		if (cmd.out_load) begin
			out_q.drawn_value     <= drawn_q;
			out_q.remaining_count <= rdwr_pkg::REMAIN_W'(count_q);
			out_q.status          <= status_q;
		end
	end

	assign sts.is_draw    = (item_q.cmd == rdwr_pkg::CMD_DRAW);
	assign sts.full       = (count_q >= rdwr_pkg::COUNT_W'(rdwr_pkg::POOL_DEPTH));
	assign sts.empty      = (count_q == '0);
	assign sts.div_last   = (step_q == rdwr_pkg::STEP_W'(rdwr_pkg::RND_W - 1));
	assign sts.shift_more = (k_plus1 < count_q);
	assign sts.count      = count_q;

	assign out_data = out_q;

endmodule
`default_nettype wire

FILE: design/rdwr_ctrl.sv
// Controller state machine of the draw pool: sequences load, modulo, read and gap close.
`default_nettype none
module rdwr_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire rdwr_pkg::dp_sts_t sts,
	output rdwr_pkg::dp_cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_RD_POS,
		ST_CAP,
		ST_SH_RD,
		ST_SH_WR,
		ST_RESP
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.capture = in_valid;
			end
			ST_EXEC: begin
				if (!sts.is_draw) begin
					cmd.load_wr  = !sts.full;
					cmd.set_full = sts.full;
				end else begin
					cmd.set_empty = sts.empty;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_RD_POS: begin
				cmd.rd_pos = 1'b1;
			end
			ST_CAP: begin
				cmd.cap_drawn = 1'b1;
			end
			ST_SH_RD: begin
				cmd.sh_rd       = sts.shift_more;
				cmd.commit_draw = !sts.shift_more;
			end
			ST_SH_WR: begin
				cmd.sh_wr = 1'b1;
			end
			ST_RESP: begin
				cmd.out_load = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// A new result takes the output register as the old one leaves.
			if ((state_q == ST_RESP) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (sts.is_draw && !sts.empty) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_DIV: begin
					if (sts.div_last) begin
						state_q <= ST_RD_POS;
					end
				end
				ST_RD_POS: begin
					state_q <= ST_CAP;
				end
				ST_CAP: begin
					state_q <= ST_SH_RD;
				end
				ST_SH_RD: begin
					if (sts.shift_more) begin
						state_q <= ST_SH_WR;
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_SH_WR: begin
					state_q <= ST_SH_RD;
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire
